// ===== sv/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
// Depends on nothing; the including scope supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define PCXD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("pcxd assertion failed");

// checked at every edge, reset included
`define PCXD_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("pcxd assertion failed");

`endif

// ===== sv/pcxd_pkg.sv =====
// Package for the PCX run-length decoder: constants, codes and the
// command/status structs between controller and datapath. No dependencies.
package pcxd_pkg;

   localparam int MAX_WIDTH     = 320;
   localparam int MAX_HEIGHT    = 400;
   localparam int LINE_BYTES    = 80;
   localparam int PALETTE_BYTES = 768;
   localparam int HEADER_BYTES  = 128;
   localparam int TALL_LIMIT    = 200;
   localparam int PAGE_TALL     = 400;
   localparam int PAGE_SHORT    = 200;

   localparam int BYTE_W    = 8;
   localparam int EDGE_W    = 16;
   localparam int SIZE_W    = 18;
   localparam int DIM_W     = 9;
   localparam int RUN_W     = 6;
   localparam int HCOUNT_W  = 7;
   localparam int PAL_W     = 10;
   localparam int ADDR_W    = 16;
   localparam int ROWPAGE_W = 10;
   localparam int PROD_W    = 17;
   localparam int MASK_W    = 4;

   localparam logic [BYTE_W-1:0] RUN_FLAGS   = 8'hC0;
   localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'd12;
   localparam logic [BYTE_W-1:0] MAKER_ID    = 8'd10;
   localparam logic [BYTE_W-1:0] VERSION_ID  = 8'd5;
   localparam logic [BYTE_W-1:0] ENCODING_ID = 8'd1;
   localparam logic [BYTE_W-1:0] BITS_ID     = 8'd8;
   localparam logic [BYTE_W-1:0] PLANES_ID   = 8'd1;

   // header byte positions
   localparam logic [HCOUNT_W-1:0] HP_MAKER     = 7'd0;
   localparam logic [HCOUNT_W-1:0] HP_VERSION   = 7'd1;
   localparam logic [HCOUNT_W-1:0] HP_ENCODING  = 7'd2;
   localparam logic [HCOUNT_W-1:0] HP_BITS      = 7'd3;
   localparam logic [HCOUNT_W-1:0] HP_LEFT_LO   = 7'd4;
   localparam logic [HCOUNT_W-1:0] HP_LEFT_HI   = 7'd5;
   localparam logic [HCOUNT_W-1:0] HP_TOP_LO    = 7'd6;
   localparam logic [HCOUNT_W-1:0] HP_TOP_HI    = 7'd7;
   localparam logic [HCOUNT_W-1:0] HP_RIGHT_LO  = 7'd8;
   localparam logic [HCOUNT_W-1:0] HP_RIGHT_HI  = 7'd9;
   localparam logic [HCOUNT_W-1:0] HP_BOTTOM_LO = 7'd10;
   localparam logic [HCOUNT_W-1:0] HP_BOTTOM_HI = 7'd11;
   localparam logic [HCOUNT_W-1:0] HP_PLANES    = 7'd65;
   localparam logic [HCOUNT_W-1:0] HP_LAST      = HCOUNT_W'(HEADER_BYTES - 1);

   typedef enum logic [1:0] {
      KIND_MODE    = 2'd0,
      KIND_PIXEL   = 2'd1,
      KIND_PALETTE = 2'd2,
      KIND_FINAL   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_SHORT_HEADER = 3'd1,
      ST_BAD_FORMAT   = 3'd2,
      ST_READ_ERROR   = 3'd3,
      ST_NO_PALETTE   = 3'd4,
      ST_TOO_LARGE    = 3'd5
   } status_type;

   typedef enum logic [4:0] {
      PH_HEADER  = 5'b00001,
      PH_PIXELS  = 5'b00010,
      PH_MARKER  = 5'b00100,
      PH_PALETTE = 5'b01000,
      PH_DONE    = 5'b10000
   } phase_type;

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_EXEC      = 7'b0000010,
      S_HDR_CALC  = 7'b0000100,
      S_HDR_CHECK = 7'b0001000,
      S_RUN       = 7'b0010000,
      S_EOB       = 7'b0100000,
      S_PAL_END   = 7'b1000000
   } ctrl_state_type;

   typedef struct packed {
      logic       capture;
      logic       hdr_byte;
      logic       hdr_calc;
      logic       hdr_load;
      logic       run_arm;
      logic       run_clear;
      logic       run_load_lit;
      logic       run_load_len;
      logic       pix_write;
      logic       eob;
      logic       pal_clear;
      logic       pal_inc;
      logic       emit;
      kind_type   kind;
      status_type status;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic eof;
      logic run_byte;
      logic marker;
      logic run_pending;
      logic run_len_zero;
      logic run_left_one;
      logic hdr_last;
      logic format_ok;
      logic too_big;
      logic empty;
      logic col_wrap;
      logic row_end;
      logic pal_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== sv/pcxd_datapath.sv =====
// Datapath of the PCX decoder: item capture, header fields, run and pixel
// counters, palette count and the result register. Depends on pcxd_pkg.
module pcxd_datapath
   import pcxd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_type,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_kind,
   output logic [MASK_W-1:0]     rsp_plane_mask,
   output logic [ADDR_W-1:0]     rsp_address,
   output logic [BYTE_W-1:0]     rsp_value,
   output logic [PAL_W-1:0]      rsp_palette_index,
   output logic [2:0]            rsp_status,
   output logic                  rsp_last
);

   localparam logic signed [SIZE_W-1:0] MAX_W_S = SIZE_W'(MAX_WIDTH);
   localparam logic signed [SIZE_W-1:0] MAX_H_S = SIZE_W'(MAX_HEIGHT);
   localparam logic signed [SIZE_W-1:0] TALL_S  = SIZE_W'(TALL_LIMIT);
   localparam logic signed [SIZE_W-1:0] ONE_S   = SIZE_W'(1);

   logic                     eof_ff;
   logic [BYTE_W-1:0]        byte_ff;
   logic [HCOUNT_W-1:0]      hdr_count_ff, hdr_count_in;
   logic                     format_ok_ff, format_ok_in;
   logic [EDGE_W-1:0]        left_ff, left_in, top_ff, top_in;
   logic [EDGE_W-1:0]        right_ff, right_in, bottom_ff, bottom_in;
   logic signed [SIZE_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [DIM_W-1:0]         image_width_ff, image_width_in;
   logic [DIM_W-1:0]         image_height_ff, image_height_in;
   logic                     tall_ff, tall_in;
   logic [DIM_W-1:0]         row_ff, row_in, col_ff, col_in;
   logic                     run_pending_ff, run_pending_in;
   logic [RUN_W-1:0]         run_length_ff, run_length_in;
   logic [RUN_W-1:0]         run_left_ff, run_left_in;
   logic [PAL_W-1:0]         pal_count_ff, pal_count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   kind_type                 rsp_kind_ff;
   logic [MASK_W-1:0]        rsp_mask_ff;
   logic [ADDR_W-1:0]        rsp_address_ff;
   logic [BYTE_W-1:0]        rsp_value_ff;
   logic [PAL_W-1:0]         rsp_index_ff;
   status_type               rsp_status_ff;
   logic                     rsp_last_ff;

   logic signed [SIZE_W-1:0] left_s, top_s, right_s, bottom_s;
   logic                     tall_cond;
   logic [DIM_W-1:0]         row_next;
   logic [PAL_W-1:0]         pal_next;
   logic [ROWPAGE_W-1:0]     row_page;
   logic [PROD_W-1:0]        addr_full;
   logic [BYTE_W-1:0]        value_sel;

   assign left_s   = {{(SIZE_W-EDGE_W){left_ff[EDGE_W-1]}}, left_ff};
   assign top_s    = {{(SIZE_W-EDGE_W){top_ff[EDGE_W-1]}}, top_ff};
   assign right_s  = {{(SIZE_W-EDGE_W){right_ff[EDGE_W-1]}}, right_ff};
   assign bottom_s = {{(SIZE_W-EDGE_W){bottom_ff[EDGE_W-1]}}, bottom_ff};

   assign tall_cond = height_ff > TALL_S;
   assign row_next  = row_ff + DIM_W'(1);
   assign pal_next  = pal_count_ff + PAL_W'(1);
   assign row_page  = ROWPAGE_W'(row_ff)
                    + (tall_ff ? ROWPAGE_W'(PAGE_TALL) : ROWPAGE_W'(PAGE_SHORT));
   assign addr_full = PROD_W'(row_page) * PROD_W'(LINE_BYTES)
                    + PROD_W'(col_ff[DIM_W-1:2]);

   assign stat.eof          = eof_ff;
   assign stat.run_byte     = (byte_ff & RUN_FLAGS) == RUN_FLAGS;
   assign stat.marker       = byte_ff == MARKER_BYTE;
   assign stat.run_pending  = run_pending_ff;
   assign stat.run_len_zero = run_length_ff == '0;
   assign stat.run_left_one = run_left_ff == RUN_W'(1);
   assign stat.hdr_last     = hdr_count_ff == HP_LAST;
   assign stat.format_ok    = format_ok_ff;
   assign stat.too_big      = (width_ff > MAX_W_S) || (height_ff > MAX_H_S);
   assign stat.empty        = (width_ff < ONE_S) || (height_ff < ONE_S);
   assign stat.col_wrap     = col_ff >= image_width_ff;
   assign stat.row_end      = row_next >= image_height_ff;
   assign stat.pal_last     = pal_next >= PAL_W'(PALETTE_BYTES);
   assign stat.out_free     = !rsp_valid_ff || !rsp_stall;

   // header fields
   always_comb begin
      hdr_count_in = hdr_count_ff;
      format_ok_in = format_ok_ff;
      left_in      = left_ff;
      top_in       = top_ff;
      right_in     = right_ff;
      bottom_in    = bottom_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      if (cmd.hdr_byte) begin
         hdr_count_in = hdr_count_ff + HCOUNT_W'(1);
         unique case (hdr_count_ff)
            HP_MAKER:     if (byte_ff != MAKER_ID) format_ok_in = 1'b0;
            HP_VERSION:   if (byte_ff != VERSION_ID) format_ok_in = 1'b0;
            HP_ENCODING:  if (byte_ff != ENCODING_ID) format_ok_in = 1'b0;
            HP_BITS:      if (byte_ff != BITS_ID) format_ok_in = 1'b0;
            HP_PLANES:    if (byte_ff != PLANES_ID) format_ok_in = 1'b0;
            HP_LEFT_LO:   left_in[7:0]    = byte_ff;
            HP_LEFT_HI:   left_in[15:8]   = byte_ff;
            HP_TOP_LO:    top_in[7:0]     = byte_ff;
            HP_TOP_HI:    top_in[15:8]    = byte_ff;
            HP_RIGHT_LO:  right_in[7:0]   = byte_ff;
            HP_RIGHT_HI:  right_in[15:8]  = byte_ff;
            HP_BOTTOM_LO: bottom_in[7:0]  = byte_ff;
            HP_BOTTOM_HI: bottom_in[15:8] = byte_ff;
            default: ;
         endcase
      end
      if (cmd.hdr_calc) begin
         width_in  = right_s - left_s + ONE_S;
         height_in = bottom_s - top_s + ONE_S;
      end
   end

   // image geometry, run and palette counters
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      tall_in         = tall_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      run_pending_in  = run_pending_ff;
      run_length_in   = run_length_ff;
      run_left_in     = run_left_ff;
      pal_count_in    = pal_count_ff;
      if (cmd.hdr_load) begin
         image_width_in  = (width_ff < ONE_S) ? '0 : width_ff[DIM_W-1:0];
         image_height_in = (height_ff < ONE_S) ? '0 : height_ff[DIM_W-1:0];
         tall_in         = tall_cond;
         row_in          = '0;
         col_in          = '0;
         run_pending_in  = 1'b0;
      end
      if (cmd.run_arm) begin
         run_pending_in = 1'b1;
         run_length_in  = byte_ff[RUN_W-1:0];
      end
      if (cmd.run_clear) run_pending_in = 1'b0;
      if (cmd.run_load_lit) run_left_in = RUN_W'(1);
      if (cmd.run_load_len) run_left_in = run_length_ff;
      if (cmd.pix_write) begin
         col_in      = col_ff + DIM_W'(1);
         run_left_in = run_left_ff - RUN_W'(1);
      end
      if (cmd.eob && stat.col_wrap) begin
         col_in = '0;
         row_in = row_next;
      end
      if (cmd.pal_clear) pal_count_in = '0;
      if (cmd.pal_inc) pal_count_in = pal_next;
   end

   always_comb begin
      unique case (cmd.kind)
         KIND_MODE:    value_sel = BYTE_W'(tall_cond);
         KIND_PIXEL:   value_sel = byte_ff;
         KIND_PALETTE: value_sel = {2'b00, byte_ff[BYTE_W-1:2]};
         KIND_FINAL:   value_sel = '0;
         default:      value_sel = '0;
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_count_ff    <= '0;
         format_ok_ff    <= 1'b1;
         left_ff         <= '0;
         top_ff          <= '0;
         right_ff        <= '0;
         bottom_ff       <= '0;
         width_ff        <= '0;
         height_ff       <= '0;
         image_width_ff  <= '0;
         image_height_ff <= '0;
         tall_ff         <= 1'b0;
         row_ff          <= '0;
         col_ff          <= '0;
         run_pending_ff  <= 1'b0;
         run_length_ff   <= '0;
         run_left_ff     <= '0;
         pal_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         hdr_count_ff    <= hdr_count_in;
         format_ok_ff    <= format_ok_in;
         left_ff         <= left_in;
         top_ff          <= top_in;
         right_ff        <= right_in;
         bottom_ff       <= bottom_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         tall_ff         <= tall_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
         run_pending_ff  <= run_pending_in;
         run_length_ff   <= run_length_in;
         run_left_ff     <= run_left_in;
         pal_count_ff    <= pal_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         eof_ff  <= req_type;
         byte_ff <= req_byte_value;
      end
      if (cmd.emit) begin
         rsp_kind_ff    <= cmd.kind;
         rsp_mask_ff    <= (cmd.kind == KIND_PIXEL)
                           ? MASK_W'(4'b0001 << col_ff[1:0]) : '0;
         rsp_address_ff <= (cmd.kind == KIND_PIXEL) ? addr_full[ADDR_W-1:0] : '0;
         rsp_value_ff   <= value_sel;
         rsp_index_ff   <= (cmd.kind == KIND_PALETTE) ? pal_count_ff : '0;
         rsp_status_ff  <= (cmd.kind == KIND_FINAL) ? cmd.status : ST_OK;
         rsp_last_ff    <= cmd.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_plane_mask    = rsp_mask_ff;
   assign rsp_address       = rsp_address_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_palette_index = rsp_index_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== sv/pcxd_ctrl.sv =====
// Controller of the PCX decoder: file phase and per-item sequencer that
// drives the datapath commands. Depends on pcxd_pkg.
module pcxd_ctrl
   import pcxd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic           fin_req;
   status_type     fin_status;

   always_comb begin
      cmd        = '0;
      cmd.kind   = KIND_MODE;
      cmd.status = ST_OK;
      state_in   = state_ff;
      phase_in   = phase_ff;
      fin_req    = 1'b0;
      fin_status = ST_OK;
      req_stall  = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (stat.eof) begin
                     fin_req    = 1'b1;
                     fin_status = ST_SHORT_HEADER;
                  end else begin
                     cmd.hdr_byte = 1'b1;
                     state_in     = stat.hdr_last ? S_HDR_CALC : S_IDLE;
                  end
               end
               PH_PIXELS: begin
                  priority if (stat.eof) begin
                     fin_req    = 1'b1;
                     fin_status = ST_READ_ERROR;
                  end else if (stat.run_pending) begin
                     cmd.run_clear    = 1'b1;
                     cmd.run_load_len = 1'b1;
                     state_in         = stat.run_len_zero ? S_EOB : S_RUN;
                  end else if (stat.run_byte) begin
                     cmd.run_arm = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.run_load_lit = 1'b1;
                     state_in         = S_RUN;
                  end
               end
               PH_MARKER: begin
                  priority if (stat.eof) begin
                     fin_req    = 1'b1;
                     fin_status = ST_NO_PALETTE;
                  end else if (stat.marker) begin
                     cmd.pal_clear = 1'b1;
                     phase_in      = PH_PALETTE;
                     state_in      = S_IDLE;
                  end else begin
                     fin_req    = 1'b1;
                     fin_status = ST_OK;
                  end
               end
               PH_PALETTE: begin
                  if (stat.eof) begin
                     fin_req    = 1'b1;
                     fin_status = ST_READ_ERROR;
                  end else if (stat.out_free) begin
                     cmd.emit    = 1'b1;
                     cmd.kind    = KIND_PALETTE;
                     cmd.last    = !stat.pal_last;
                     cmd.pal_inc = 1'b1;
                     state_in    = stat.pal_last ? S_PAL_END : S_IDLE;
                  end
               end
               PH_DONE: state_in = S_IDLE;
               default: state_in = S_IDLE;
            endcase
         end
         S_HDR_CALC: begin
            cmd.hdr_calc = 1'b1;
            state_in     = S_HDR_CHECK;
         end
         S_HDR_CHECK: begin
            priority if (!stat.format_ok) begin
               fin_req    = 1'b1;
               fin_status = ST_BAD_FORMAT;
            end else if (stat.too_big) begin
               fin_req    = 1'b1;
               fin_status = ST_TOO_LARGE;
            end else if (stat.out_free) begin
               cmd.emit     = 1'b1;
               cmd.kind     = KIND_MODE;
               cmd.last     = 1'b1;
               cmd.hdr_load = 1'b1;
               phase_in     = stat.empty ? PH_MARKER : PH_PIXELS;
               state_in     = S_IDLE;
            end
         end
         S_RUN: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.kind      = KIND_PIXEL;
               cmd.last      = stat.run_left_one;
               cmd.pix_write = 1'b1;
               if (stat.run_left_one) state_in = S_EOB;
            end
         end
         S_EOB: begin
            cmd.eob = 1'b1;
            if (stat.col_wrap && stat.row_end) phase_in = PH_MARKER;
            state_in = S_IDLE;
         end
         S_PAL_END: begin
            fin_req    = 1'b1;
            fin_status = ST_OK;
         end
         default: state_in = S_IDLE;
      endcase

      // final status: one transfer, then everything later is dropped
      if (fin_req && stat.out_free) begin
         cmd.emit   = 1'b1;
         cmd.kind   = KIND_FINAL;
         cmd.status = fin_status;
         cmd.last   = 1'b1;
         phase_in   = PH_DONE;
         state_in   = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_HEADER;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== sv/pcx_rle_image_decoder.sv =====
// PCX 8-bit run-length decoder, one file byte per input transfer plus an
// end-of-file transfer. Results leave through one output register, one
// transfer per cycle at most. Each item is accepted, then decoded; a byte
// that writes pixels then passes the pixel sequencer (one write per cycle
// while the result channel is not stalled) and an end-of-byte step, the
// last header byte an edge subtract, then a range check, and the last palette
// byte its entry, then the final status. A stalled result channel holds them.
// Depends on pcxd_pkg, pcxd_ctrl, pcxd_datapath.
`include "assert_macros.svh"

module pcx_rle_image_decoder
   import pcxd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [BYTE_W-1:0] req_byte_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [MASK_W-1:0] rsp_plane_mask,
   output logic [ADDR_W-1:0] rsp_address,
   output logic [BYTE_W-1:0] rsp_value,
   output logic [PAL_W-1:0]  rsp_palette_index,
   output logic [2:0]        rsp_status,
   output logic              rsp_last
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   pcxd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcxd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_byte_value    (req_byte_value),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_plane_mask    (rsp_plane_mask),
      .rsp_address       (rsp_address),
      .rsp_value         (rsp_value),
      .rsp_palette_index (rsp_palette_index),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   `PCXD_ASSERT(a_emit_needs_room, cmd.emit |-> stat.out_free)
   `PCXD_ASSERT(a_no_emit_when_accepting, !req_stall |-> !cmd.emit)
   `PCXD_ASSERT(a_pixel_one_plane, (rsp_valid && rsp_kind == KIND_PIXEL) |-> $onehot(rsp_plane_mask))
   `PCXD_ASSERT_ALWAYS(a_empty_after_reset, reset |=> !rsp_valid)

endmodule
